### rtl/tss_pkg.sv
`default_nettype none
package tss_pkg;

	// Width of the internal point counter; the result shows it saturated to 24 bits.
	localparam int COUNT_BITS = 24;

	localparam int LAT_W   = 31;
	localparam int LON_W   = 32;
	localparam int ALT_W   = 21;
	localparam int LEG_W   = 32;
	localparam int TS_W    = 32;
	localparam int CLIMB_W = 40;
	localparam int DIST_W  = 48;
	localparam int CNT_W   = 24;
	localparam int SPEED_W = 32;

	localparam int S_TDATA_W = 152;
	localparam int M_TDATA_W = 384;

	// One quotient bit per step over the full distance width.
	localparam int DIV_STEPS  = DIST_W;
	localparam int DIV_CNT_W  = $clog2(DIV_STEPS + 1);

	typedef struct packed {
		logic signed [LAT_W-1:0] latitude;
		logic signed [LON_W-1:0] longitude;
		logic signed [ALT_W-1:0] altitude_cm;
		logic [LEG_W-1:0]        leg_length_mm;
		logic [TS_W-1:0]         timestamp;
		logic                    first_point;
		logic                    last_point;
	} point_t;

	typedef struct packed {
		logic signed [LAT_W-1:0] min_lat;
		logic signed [LAT_W-1:0] max_lat;
		logic signed [LON_W-1:0] min_lon;
		logic signed [LON_W-1:0] max_lon;
		logic signed [ALT_W-1:0] min_alt;
		logic signed [ALT_W-1:0] max_alt;
		logic [CLIMB_W-1:0]      climb_total;
		logic [CLIMB_W-1:0]      descent_total;
		logic [DIST_W-1:0]       distance_total;
		logic [CNT_W-1:0]        point_count;
		logic [TS_W-1:0]         duration_s;
		logic [SPEED_W-1:0]      speed_mm_s;
	} result_t;

	typedef struct packed {
		logic capture;
		logic update;
		logic div_load;
		logic div_step;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic last;
		logic div_done;
	} status_t;

endpackage
`default_nettype wire

### rtl/tss_ctrl.sv
`default_nettype none
module tss_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            s_tvalid,
	output logic                 s_tready,
	output logic                 m_tvalid,
	input  wire logic            m_tready,
	input  wire tss_pkg::status_t status,
	output tss_pkg::cmd_t        cmd
);
	import tss_pkg::*;

	localparam logic [2:0] ST_IDLE    = 3'd0;
	localparam logic [2:0] ST_UPDATE  = 3'd1;
	localparam logic [2:0] ST_DIVLOAD = 3'd2;
	localparam logic [2:0] ST_DIVRUN  = 3'd3;
	localparam logic [2:0] ST_PUBLISH = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       m_valid_q;
	logic       out_free;

	assign out_free = !m_valid_q || m_tready;
	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_valid_q;

	always_comb begin
		state_d      = state_q;
		cmd          = '0;
		cmd.capture  = s_tvalid && (state_q == ST_IDLE);
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) state_d = ST_UPDATE;
			end
			ST_UPDATE: begin
				cmd.update = 1'b1;
				state_d    = status.last ? ST_DIVLOAD : ST_IDLE;
			end
			ST_DIVLOAD: begin
				cmd.div_load = 1'b1;
				state_d      = ST_DIVRUN;
			end
			ST_DIVRUN: begin
				cmd.div_step = 1'b1;
				if (status.div_done) state_d = ST_PUBLISH;
			end
			ST_PUBLISH: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			m_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	a_update_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_UPDATE |-> $past(s_tvalid && s_tready))
		else $error("update without an accepted item");

	a_divide_only_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIVLOAD |-> $past(state_q == ST_UPDATE && status.last))
		else $error("divide started for a point that does not close a segment");

	a_result_from_publish: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_valid_q) |-> $past(state_q == ST_PUBLISH))
		else $error("result raised outside publish");

	a_done_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		status.div_done |-> state_q == ST_DIVRUN)
		else $error("divider finished while not running");

endmodule
`default_nettype wire

### rtl/tss_datapath.sv
`default_nettype none
module tss_datapath (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire tss_pkg::cmd_t   cmd,
	input  wire tss_pkg::point_t point_in,
	output tss_pkg::status_t     status,
	output tss_pkg::result_t     result
);
	import tss_pkg::*;

	localparam int OUT_COUNT_MAX = 2**CNT_W - 1;

	point_t                  pt_q;
	logic                    open_q;
	logic signed [LAT_W-1:0] lat_lo_q, lat_hi_q;
	logic signed [LON_W-1:0] lon_lo_q, lon_hi_q;
	logic signed [ALT_W-1:0] alt_lo_q, alt_hi_q, prev_q;
	logic [CLIMB_W-1:0]      climb_q, descent_q;
	logic [DIST_W-1:0]       dist_q;
	logic [COUNT_BITS-1:0]   points_q;
	logic [TS_W-1:0]         start_q, dur_q;
	logic [TS_W-1:0]         rem_q;
	logic [DIST_W-1:0]       quo_q;
	logic [DIV_CNT_W-1:0]    div_cnt_q;
	result_t                 res_q;

	logic                    new_seg;
	logic [ALT_W:0]          delta;
	logic [ALT_W:0]          mag;
	logic                    rising;
	logic [CLIMB_W:0]        climb_add, descent_add;
	logic [DIST_W:0]         dist_add;
	logic [TS_W:0]           rem_sh, diff;
	logic                    ge;
	logic [31:0]             count_wide;
	logic [CNT_W-1:0]        count_out;
	logic [SPEED_W-1:0]      speed;

	always_comb begin
		new_seg     = pt_q.first_point || !open_q;
		delta       = {pt_q.altitude_cm[ALT_W-1], pt_q.altitude_cm} - {prev_q[ALT_W-1], prev_q};
		rising      = !delta[ALT_W] && (delta != '0);
		mag         = delta[ALT_W] ? (~delta + 1'b1) : delta;
		climb_add   = {1'b0, climb_q} + (CLIMB_W+1)'(mag);
		descent_add = {1'b0, descent_q} + (CLIMB_W+1)'(mag);
		dist_add    = {1'b0, dist_q} + (DIST_W+1)'(pt_q.leg_length_mm);

		rem_sh = {rem_q, quo_q[DIST_W-1]};
		diff   = rem_sh - {1'b0, dur_q};
		ge     = !diff[TS_W];

		count_wide = 32'(points_q);
		count_out  = (count_wide > 32'(OUT_COUNT_MAX)) ? '1 : count_wide[CNT_W-1:0];
		if (dur_q == '0) begin
			speed = '0;
		end else if (|quo_q[DIST_W-1:SPEED_W]) begin
			speed = '1;
		end else begin
			speed = quo_q[SPEED_W-1:0];
		end
	end

	assign status.last     = pt_q.last_point;
	assign status.div_done = (div_cnt_q == DIV_CNT_W'(DIV_STEPS - 1));
	assign result          = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q    <= 1'b0;
			div_cnt_q <= DIV_CNT_W'(DIV_STEPS);
		end else begin
			if (cmd.update) open_q <= !pt_q.last_point;
			if (cmd.div_load) begin
				div_cnt_q <= '0;
			end else if (cmd.div_step) begin
				div_cnt_q <= div_cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) pt_q <= point_in;

		if (cmd.update) begin
			prev_q <= pt_q.altitude_cm;
			if (new_seg) begin
				lat_lo_q  <= pt_q.latitude;
				lat_hi_q  <= pt_q.latitude;
				lon_lo_q  <= pt_q.longitude;
				lon_hi_q  <= pt_q.longitude;
				alt_lo_q  <= pt_q.altitude_cm;
				alt_hi_q  <= pt_q.altitude_cm;
				climb_q   <= '0;
				descent_q <= '0;
				dist_q    <= '0;
				points_q  <= COUNT_BITS'(1);
				start_q   <= pt_q.timestamp;
				dur_q     <= '0;
			end else begin
				if (pt_q.latitude < lat_lo_q)     lat_lo_q <= pt_q.latitude;
				if (pt_q.latitude > lat_hi_q)     lat_hi_q <= pt_q.latitude;
				if (pt_q.longitude < lon_lo_q)    lon_lo_q <= pt_q.longitude;
				if (pt_q.longitude > lon_hi_q)    lon_hi_q <= pt_q.longitude;
				if (pt_q.altitude_cm < alt_lo_q)  alt_lo_q <= pt_q.altitude_cm;
				if (pt_q.altitude_cm > alt_hi_q)  alt_hi_q <= pt_q.altitude_cm;
				dist_q <= dist_add[DIST_W] ? '1 : dist_add[DIST_W-1:0];
				if (rising) begin
					climb_q <= climb_add[CLIMB_W] ? '1 : climb_add[CLIMB_W-1:0];
				end else begin
					descent_q <= descent_add[CLIMB_W] ? '1 : descent_add[CLIMB_W-1:0];
				end
				if (points_q != '1) points_q <= points_q + 1'b1;
				dur_q <= pt_q.timestamp - start_q;
			end
		end

		// Restoring division of the distance by the duration, one quotient bit a cycle.
		if (cmd.div_load) begin
			rem_q <= '0;
			quo_q <= dist_q;
		end else if (cmd.div_step) begin
			rem_q <= ge ? diff[TS_W-1:0] : rem_sh[TS_W-1:0];
			quo_q <= {quo_q[DIST_W-2:0], ge};
		end

		if (cmd.out_load) begin
			res_q.min_lat        <= lat_lo_q;
			res_q.max_lat        <= lat_hi_q;
			res_q.min_lon        <= lon_lo_q;
			res_q.max_lon        <= lon_hi_q;
			res_q.min_alt        <= alt_lo_q;
			res_q.max_alt        <= alt_hi_q;
			res_q.climb_total    <= climb_q;
			res_q.descent_total  <= descent_q;
			res_q.distance_total <= dist_q;
			res_q.point_count    <= count_out;
			res_q.duration_s     <= dur_q;
			res_q.speed_mm_s     <= speed;
		end
	end

endmodule
`default_nettype wire

### rtl/track_segment_statistics.sv
// Track segment statistics.
//
// Points arrive on the slave stream, one item per point, with first_point in
// s_tuser and last_point in s_tlast. The block keeps the bounding box, the
// altitude range, climb and descent, summed leg length, point count and
// start time of the open segment. A point flagged last closes the segment
// and one result item leaves on the master stream; other points give none.
//
// Sequence: a point that does not close a segment is accepted, then the
// accumulators are updated. A closing point goes on from the update to a
// divider load, the restoring divider that forms the mean speed, one quotient
// bit per cycle, and the load of the output register. s_tready is high
// whenever the controller is idle, so the next segment may start while a
// finished result still waits in the output register. If the receiver
// stalls, a second result is held in the accumulators and the divider, with
// s_tready low, until the output register frees.
//
// Reset (arst_n low) closes any open segment and empties the output register;
// a result still waiting there is discarded, and no result is invented.
`default_nettype none
module track_segment_statistics (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           s_tvalid,
	output logic                                s_tready,
	// latitude, longitude, altitude_cm, leg_length_mm, timestamp, padding
	input  wire logic [tss_pkg::S_TDATA_W-1:0]  s_tdata,
	// first_point
	input  wire logic                           s_tuser,
	// last_point
	input  wire logic                           s_tlast,
	output logic                                m_tvalid,
	input  wire logic                           m_tready,
	// min_lat, max_lat, min_lon, max_lon, min_alt, max_alt, climb_total,
	// descent_total, distance_total, point_count, duration_s, speed_mm_s
	output logic [tss_pkg::M_TDATA_W-1:0]       m_tdata
);
	import tss_pkg::*;

	point_t  point;
	result_t result;
	cmd_t    cmd;
	status_t status;

	// Unpack the input item; the top bits of s_tdata are padding.
	assign point.latitude      = s_tdata[30:0];
	assign point.longitude     = s_tdata[62:31];
	assign point.altitude_cm   = s_tdata[83:63];
	assign point.leg_length_mm = s_tdata[115:84];
	assign point.timestamp     = s_tdata[147:116];
	assign point.first_point   = s_tuser;
	assign point.last_point    = s_tlast;

	tss_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.status   (status),
		.cmd      (cmd)
	);

	tss_datapath u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.point_in (point),
		.status   (status),
		.result   (result)
	);

	// First field in the lowest bits; the fields fill whole bytes exactly.
	assign m_tdata = {result.speed_mm_s, result.duration_s, result.point_count,
		result.distance_total, result.descent_total, result.climb_total,
		result.max_alt, result.min_alt, result.max_lon, result.min_lon,
		result.max_lat, result.min_lat};

endmodule
`default_nettype wire
